// ===== src/nih_pkg.sv =====
package nih_pkg;

  localparam logic [31:0] SEED_GOLDEN = 32'h9e3779b9;
  localparam logic [31:0] SEED_OFFSET = 32'd3923095;
  localparam logic [31:0] ID_SEED     = SEED_GOLDEN + 32'd4 + SEED_OFFSET;
  localparam logic [3:0]  BLOCK_LAST  = 4'd11;
  localparam int          MIX_STEPS   = 7;
  localparam int          MIX_ROT [MIX_STEPS] = '{14, 11, 25, 16, 4, 14, 24};

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] idh;
    logic        use_id;
  } mix_word_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

// ===== src/nih_acc.sv =====
module nih_acc import nih_pkg::*; #(
  parameter int MAX_NAME_LENGTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [7:0]  in_name_byte,
  input  logic [7:0]  in_name_length,
  input  logic [31:0] in_object_id,
  input  logic        in_use_id,
  input  logic        in_last_byte,
  output logic        launch_vld,
  output mix_word_t   launch_data
);

  logic [31:0] a_r, b_r, c_r;
  logic [3:0]  pos_r;
  logic        in_name_r;
  logic        launch_vld_r;
  mix_word_t   launch_r;

  logic        accept;
  logic        has_len;
  logic [31:0] seed_len;
  logic [31:0] seed;
  logic [3:0]  pos_cur;
  logic [3:0]  pos_nxt;
  logic [31:0] add;
  logic [31:0] base_a, base_b, base_c;
  logic [31:0] a_nxt, b_nxt, c_nxt;

  assign accept  = in_valid && en;
  assign has_len = (in_name_length != 8'd0);

  always_comb begin
    if ({24'd0, in_name_length} > 32'(MAX_NAME_LENGTH)) begin
      seed_len = 32'(MAX_NAME_LENGTH);
    end else begin
      seed_len = {24'd0, in_name_length};
    end
    seed    = SEED_GOLDEN + SEED_OFFSET + seed_len;
    base_a  = in_name_r ? a_r : seed;
    base_b  = in_name_r ? b_r : seed;
    base_c  = in_name_r ? c_r : seed;
    pos_cur = in_name_r ? pos_r : 4'd0;
    add     = {24'd0, in_name_byte} << {~pos_cur[1:0], 3'b000};
    a_nxt   = base_a;
    b_nxt   = base_b;
    c_nxt   = base_c;
    pos_nxt = pos_cur;
    if (has_len) begin
      if (pos_cur < 4'd4) begin
        a_nxt = base_a + add;
      end else if (pos_cur < 4'd8) begin
        b_nxt = base_b + add;
      end else begin
        c_nxt = base_c + add;
      end
      pos_nxt = (pos_cur == BLOCK_LAST) ? 4'd0 : pos_cur + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_name_r    <= 1'b0;
      pos_r        <= 4'd0;
      launch_vld_r <= 1'b0;
    end else if (en) begin
      launch_vld_r <= accept && in_last_byte;
      if (accept) begin
        in_name_r <= !in_last_byte;
        pos_r     <= in_last_byte ? 4'd0 : pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
    if (en) begin
      launch_r.a      <= a_nxt;
      launch_r.b      <= b_nxt;
      launch_r.c      <= c_nxt;
      launch_r.idh    <= ID_SEED + in_object_id;
      launch_r.use_id <= in_use_id;
    end
  end

  assign launch_vld  = launch_vld_r;
  assign launch_data = launch_r;

endmodule

// ===== src/nih_mix_stage.sv =====
module nih_mix_stage import nih_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      prev_vld,
  input  mix_word_t prev_data,
  output logic      stage_vld,
  output mix_word_t stage_data
);

  logic      vld_r;
  mix_word_t data_r;
  mix_word_t data_nxt;

  always_comb begin
    data_nxt = prev_data;
    case (STEP % 3)
      0: data_nxt.c = (prev_data.c ^ prev_data.b) - rotl32(prev_data.b, MIX_ROT[STEP]);
      1: data_nxt.a = (prev_data.a ^ prev_data.c) - rotl32(prev_data.c, MIX_ROT[STEP]);
      default: data_nxt.b = (prev_data.b ^ prev_data.a) - rotl32(prev_data.a, MIX_ROT[STEP]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign stage_vld  = vld_r;
  assign stage_data = data_r;

endmodule

// ===== src/name_and_id_hash_unit.sv =====
// A last byte passes the launch register, seven mix registers and the output register.
// Throughput: one input transfer per cycle unless the output stalls; the seven final-mix
// steps form a pipeline. A stalled output holds the whole pipeline and drops in_ready.
// Reset: synchronous, active low; clears all valid bits and the in-name state.
module name_and_id_hash_unit import nih_pkg::*; #(
  parameter int MAX_NAME_LENGTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_name_byte,
  input  logic [7:0]  in_name_length,
  input  logic [31:0] in_object_id,
  input  logic        in_use_id,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value
);

  logic        en;
  logic        stg_vld  [MIX_STEPS+1];
  mix_word_t   stg_data [MIX_STEPS+1];
  logic        out_valid_r;
  logic [31:0] hash_r;
  logic [31:0] hash_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  nih_acc #(.MAX_NAME_LENGTH(MAX_NAME_LENGTH)) u_acc (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .in_name_byte   (in_name_byte),
    .in_name_length (in_name_length),
    .in_object_id   (in_object_id),
    .in_use_id      (in_use_id),
    .in_last_byte   (in_last_byte),
    .launch_vld     (stg_vld[0]),
    .launch_data    (stg_data[0])
  );

  for (genvar i = 0; i < MIX_STEPS; i++) begin : g_mix
    nih_mix_stage #(.STEP(i)) u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .prev_vld   (stg_vld[i]),
      .prev_data  (stg_data[i]),
      .stage_vld  (stg_vld[i+1]),
      .stage_data (stg_data[i+1])
    );
  end

  assign hash_nxt = stg_data[MIX_STEPS].c
                  ^ (stg_data[MIX_STEPS].use_id ? rotl32(stg_data[MIX_STEPS].idh, 8) : 32'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg_vld[MIX_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hash_r <= hash_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;

endmodule

// ===== src/nih_checker.sv =====
module nih_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash_value))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_free_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind name_and_id_hash_unit nih_checker u_nih_checker (.*);
